### rtl/ebrt_pkg.sv
// shared types, constants and codes for the expiring block rule table
package ebrt_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int SWEEP_SPAN    = 16;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES) + 1;
	localparam int SW_W          = $clog2(SWEEP_SPAN + 1);
	// live*10 >= entries*9 rewritten as live >= ceil(entries*9/10)
	localparam int LIVE_THRESH   = (TABLE_ENTRIES * 9 + 9) / 10;

	localparam logic [1:0] CMD_SEARCH = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_EXPIRED   = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_IP     = 2'd1,
		KIND_CLIENT = 2'd2
	} idx_kind_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] ip_key;
		logic [63:0] client_key;
		logic [31:0] expire_time;
		logic [1:0]  punish_level;
		logic [31:0] now;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic [1:0] level;
	} out_beat_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [63:0] client;
		logic [31:0] expiry;
		logic [1:0]  level;
		logic [1:0]  kind;
	} entry_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_FIND_INIT,
		OP_FIND_RD,
		OP_FIND_CMP,
		OP_SET_LEVEL,
		OP_SET_STATUS,
		OP_TGT_FROM_HIT,
		OP_REFRESH,
		OP_UNINDEX,
		OP_RCLR,
		OP_RELEASE,
		OP_SW_INIT,
		OP_SW_RD,
		OP_SW_CAPT,
		OP_SW_NEXT,
		OP_SW_FIN,
		OP_POP_RD,
		OP_POP_TAKE,
		OP_NEW_SLOT,
		OP_WRITE_NEW
	} op_t;

	typedef enum logic [2:0] {
		FSEL_SEARCH,
		FSEL_ADD,
		FSEL_DEL,
		FSEL_TGT_IP,
		FSEL_TGT_CL
	} fsel_t;

	typedef enum logic [2:0] {
		RET_SEARCH,
		RET_ADD,
		RET_DEL,
		RET_UNIP,
		RET_UNCL
	} ret_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_FIND_RD,
		S_FIND_CMP,
		S_RET,
		S_DEL_REL,
		S_DS_START,
		S_DS_IP,
		S_DS_CL,
		S_DS_END,
		S_SWEEP_CHK,
		S_SW_RD,
		S_SW_CMP,
		S_SW_NEXT,
		S_ALLOC,
		S_POP,
		S_WRITE,
		S_DONE
	} ctl_state_t;

	typedef struct packed {
		op_t        op;
		fsel_t      fsel;
		logic [1:0] st;
	} ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       exp_lt_now;
		logic       ip_nz;
		logic       cl_nz;
		logic       add_kind_nz;
		logic       scan_end;
		logic       match;
		logic       scan_expired;
		logic       tgt_ip_nz;
		logic       tgt_cl_nz;
		logic       sweep_hit;
		logic       sweep_end;
		logic       live_high;
		logic       free_nz;
		logic       table_full;
		logic       r;
	} dp_stat_t;

endpackage

### rtl/ebrt_ram.sv
// generic single port ram with registered read
module ebrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

### rtl/ebrt_datapath.sv
// rule table datapath: slot and free stack memories, counters, key compare
module ebrt_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  ebrt_pkg::in_beat_t  item,
	input  ebrt_pkg::ctl_t      ctl,
	output ebrt_pkg::dp_stat_t  stat,
	output ebrt_pkg::out_beat_t result
);
	import ebrt_pkg::*;

	in_beat_t         in_q;
	idx_kind_t        fkind_q;
	logic [31:0]      fip_q;
	logic [63:0]      fcl_q;
	logic [CNT_W-1:0] scan_q;
	logic [IDX_W-1:0] hit_q;
	entry_t           scan_ent_q;
	entry_t           tgt_q;
	logic [IDX_W-1:0] tgt_idx_q;
	logic [IDX_W-1:0] pos_q;
	logic             r_q;
	logic [CNT_W-1:0] sw_i_q;
	logic [SW_W-1:0]  sw_cnt_q;
	logic [CNT_W-1:0] sweep_pos_q;
	logic [CNT_W-1:0] free_cnt_q;
	logic [CNT_W-1:0] next_unused_q;
	logic [CNT_W-1:0] live_q;
	out_beat_t        res_q;

	idx_kind_t        add_kind;
	entry_t           ent_rd;
	entry_t           ent_wd;
	logic [$bits(entry_t)-1:0] ent_rbits;
	logic [IDX_W-1:0] ent_addr;
	logic             ent_we;
	logic [IDX_W-1:0] stk_addr;
	logic [IDX_W-1:0] stk_rd;
	logic             stk_we;
	logic             stk_room;
	logic [CNT_W-1:0] fc_dec;
	logic [CNT_W:0]   sw_sum;
	logic [CNT_W:0]   sw_wrap;
	logic [CNT_W-1:0] sw_pos_nxt;
	logic             match;

	assign ent_rd = entry_t'(ent_rbits);

	ebrt_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_ENTRIES)) u_slots (
		.clk   (clk),
		.we    (ent_we),
		.addr  (ent_addr),
		.wdata (ent_wd),
		.rdata (ent_rbits)
	);

	ebrt_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_ENTRIES)) u_free_stack (
		.clk   (clk),
		.we    (stk_we),
		.addr  (stk_addr),
		.wdata (tgt_idx_q),
		.rdata (stk_rd)
	);

	always_comb begin
		if (in_q.ip_key != '0 && in_q.client_key == '0) begin
			add_kind = KIND_IP;
		end else if (in_q.ip_key == '0 && in_q.client_key != '0) begin
			add_kind = KIND_CLIENT;
		end else begin
			add_kind = KIND_NONE;
		end
	end

	always_comb begin
		match = 1'b0;
		if (ent_rd.kind == fkind_q) begin
			if (fkind_q == KIND_IP) begin
				match = (ent_rd.ip == fip_q);
			end else begin
				match = (ent_rd.client == fcl_q);
			end
		end
	end

	assign stk_room = (free_cnt_q < CNT_W'(TABLE_ENTRIES));
	assign fc_dec   = free_cnt_q - CNT_W'(1);

	// sweep position advance with wrap at the fill mark
	always_comb begin
		sw_sum  = {1'b0, sweep_pos_q} + (CNT_W + 1)'(sw_cnt_q);
		sw_wrap = sw_sum;
		if (sw_sum >= {1'b0, next_unused_q}) begin
			sw_wrap = sw_sum - {1'b0, next_unused_q};
		end
		if (sw_wrap >= {1'b0, next_unused_q}) begin
			sw_pos_nxt = '0;
		end else begin
			sw_pos_nxt = sw_wrap[CNT_W-1:0];
		end
	end

	always_comb begin
		ent_we = 1'b0;
		ent_addr = scan_q[IDX_W-1:0];
		ent_wd = scan_ent_q;
		case (ctl.op)
			OP_SW_RD: begin
				ent_addr = sw_i_q[IDX_W-1:0];
			end
			OP_REFRESH: begin
				ent_we = 1'b1;
				ent_addr = hit_q;
				ent_wd.expiry = in_q.expire_time;
				ent_wd.level = in_q.punish_level;
			end
			OP_UNINDEX: begin
				ent_we = 1'b1;
				ent_addr = hit_q;
				ent_wd.kind = KIND_NONE;
			end
			OP_RELEASE: begin
				ent_we = 1'b1;
				ent_addr = tgt_idx_q;
				ent_wd = '0;
				ent_wd.expiry = tgt_q.expiry;
				ent_wd.kind = KIND_NONE;
			end
			OP_WRITE_NEW: begin
				ent_we = 1'b1;
				ent_addr = pos_q;
				ent_wd.ip = in_q.ip_key;
				ent_wd.client = in_q.client_key;
				ent_wd.expiry = in_q.expire_time;
				ent_wd.level = in_q.punish_level;
				ent_wd.kind = add_kind;
			end
			default: begin
			end
		endcase
	end

	assign stk_we   = (ctl.op == OP_RELEASE) && stk_room;
	assign stk_addr = (ctl.op == OP_POP_RD) ? fc_dec[IDX_W-1:0] : free_cnt_q[IDX_W-1:0];

	always_comb begin
		stat.cmd          = in_q.cmd;
		stat.exp_lt_now   = in_q.expire_time < in_q.now;
		stat.ip_nz        = in_q.ip_key != '0;
		stat.cl_nz        = in_q.client_key != '0;
		stat.add_kind_nz  = add_kind != KIND_NONE;
		stat.scan_end     = scan_q >= next_unused_q;
		stat.match        = match;
		stat.scan_expired = scan_ent_q.expiry < in_q.now;
		stat.tgt_ip_nz    = tgt_q.ip != '0;
		stat.tgt_cl_nz    = tgt_q.client != '0;
		stat.sweep_hit    = ent_rd.level != '0 && ent_rd.expiry < in_q.now;
		stat.sweep_end    = sw_i_q >= next_unused_q || sw_cnt_q >= SW_W'(SWEEP_SPAN);
		stat.live_high    = live_q >= CNT_W'(LIVE_THRESH);
		stat.free_nz      = free_cnt_q != '0;
		stat.table_full   = next_unused_q >= CNT_W'(TABLE_ENTRIES);
		stat.r            = r_q;
	end

	assign result = res_q;

	// counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_cnt_q <= '0;
			next_unused_q <= '0;
			sweep_pos_q <= '0;
			live_q <= '0;
			r_q <= 1'b0;
			res_q <= '0;
		end else begin
			case (ctl.op)
				OP_LOAD: begin
					res_q <= '0;
				end
				OP_SET_LEVEL: begin
					res_q.level <= scan_ent_q.level;
				end
				OP_SET_STATUS: begin
					res_q.status <= ctl.st;
				end
				OP_UNINDEX: begin
					r_q <= 1'b1;
				end
				OP_RCLR: begin
					r_q <= 1'b0;
				end
				OP_RELEASE: begin
					if (stk_room) begin
						free_cnt_q <= free_cnt_q + CNT_W'(1);
					end
					if (live_q != '0) begin
						live_q <= live_q - CNT_W'(1);
					end
				end
				OP_SW_FIN: begin
					sweep_pos_q <= sw_pos_nxt;
				end
				OP_POP_RD: begin
					free_cnt_q <= fc_dec;
				end
				OP_NEW_SLOT: begin
					next_unused_q <= next_unused_q + CNT_W'(1);
				end
				OP_WRITE_NEW: begin
					live_q <= live_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				in_q <= item;
			end
			OP_FIND_INIT: begin
				scan_q <= '0;
				fip_q <= in_q.ip_key;
				fcl_q <= in_q.client_key;
				case (ctl.fsel)
					FSEL_SEARCH: begin
						fkind_q <= (in_q.client_key != '0) ? KIND_CLIENT : KIND_IP;
					end
					FSEL_ADD: begin
						fkind_q <= add_kind;
					end
					FSEL_DEL: begin
						fkind_q <= (in_q.ip_key != '0) ? KIND_IP : KIND_CLIENT;
					end
					FSEL_TGT_IP: begin
						fkind_q <= KIND_IP;
						fip_q <= tgt_q.ip;
					end
					FSEL_TGT_CL: begin
						fkind_q <= KIND_CLIENT;
						fcl_q <= tgt_q.client;
					end
					default: begin
						fkind_q <= KIND_IP;
					end
				endcase
			end
			OP_FIND_CMP: begin
				if (match) begin
					scan_ent_q <= ent_rd;
					hit_q <= scan_q[IDX_W-1:0];
				end else begin
					scan_q <= scan_q + CNT_W'(1);
				end
			end
			OP_TGT_FROM_HIT: begin
				tgt_q <= scan_ent_q;
				tgt_idx_q <= hit_q;
			end
			OP_SW_INIT: begin
				sw_i_q <= sweep_pos_q;
				sw_cnt_q <= '0;
			end
			OP_SW_RD: begin
				sw_cnt_q <= sw_cnt_q + SW_W'(1);
			end
			OP_SW_CAPT: begin
				tgt_q <= ent_rd;
				tgt_idx_q <= sw_i_q[IDX_W-1:0];
			end
			OP_SW_NEXT: begin
				sw_i_q <= sw_i_q + CNT_W'(1);
			end
			OP_POP_TAKE: begin
				pos_q <= stk_rd;
			end
			OP_NEW_SLOT: begin
				pos_q <= next_unused_q[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end
endmodule

### rtl/ebrt_ctrl.sv
// rule table sequencer: command dispatch, key scan, slot delete, sweep, allocate
module ebrt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ebrt_pkg::dp_stat_t stat,
	output ebrt_pkg::ctl_t     ctl,
	output logic               busy,
	output logic               done
);
	import ebrt_pkg::*;

	ctl_state_t state_q, state_d;
	ret_t       ret_q, ret_d;
	logic       found_q, found_d;
	logic       ds_sweep_q, ds_sweep_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= RET_SEARCH;
			found_q <= 1'b0;
			ds_sweep_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			found_q <= found_d;
			ds_sweep_q <= ds_sweep_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		found_d = found_q;
		ds_sweep_d = ds_sweep_q;
		ctl.op = OP_NOP;
		ctl.fsel = FSEL_SEARCH;
		ctl.st = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.op = OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.cmd)
					CMD_SEARCH: begin
						ctl.op = OP_FIND_INIT;
						ctl.fsel = FSEL_SEARCH;
						ret_d = RET_SEARCH;
						state_d = S_FIND_RD;
					end
					CMD_ADD: begin
						if (stat.exp_lt_now) begin
							ctl.op = OP_SET_STATUS;
							ctl.st = ST_EXPIRED;
							state_d = S_DONE;
						end else if (stat.add_kind_nz) begin
							ctl.op = OP_FIND_INIT;
							ctl.fsel = FSEL_ADD;
							ret_d = RET_ADD;
							state_d = S_FIND_RD;
						end else begin
							state_d = S_SWEEP_CHK;
						end
					end
					CMD_DELETE: begin
						if (stat.ip_nz || stat.cl_nz) begin
							ctl.op = OP_FIND_INIT;
							ctl.fsel = FSEL_DEL;
							ret_d = RET_DEL;
							state_d = S_FIND_RD;
						end else begin
							ctl.op = OP_SET_STATUS;
							ctl.st = ST_NOT_FOUND;
							state_d = S_DONE;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_FIND_RD: begin
				if (stat.scan_end) begin
					found_d = 1'b0;
					state_d = S_RET;
				end else begin
					ctl.op = OP_FIND_RD;
					state_d = S_FIND_CMP;
				end
			end
			S_FIND_CMP: begin
				ctl.op = OP_FIND_CMP;
				if (stat.match) begin
					found_d = 1'b1;
					state_d = S_RET;
				end else begin
					state_d = S_FIND_RD;
				end
			end
			S_RET: begin
				case (ret_q)
					RET_SEARCH: begin
						if (!found_q) begin
							state_d = S_DONE;
						end else if (stat.scan_expired) begin
							ctl.op = OP_TGT_FROM_HIT;
							ds_sweep_d = 1'b0;
							state_d = S_DS_START;
						end else begin
							ctl.op = OP_SET_LEVEL;
							state_d = S_DONE;
						end
					end
					RET_ADD: begin
						if (found_q) begin
							ctl.op = OP_REFRESH;
							state_d = S_DONE;
						end else begin
							state_d = S_SWEEP_CHK;
						end
					end
					RET_DEL: begin
						if (found_q) begin
							ctl.op = OP_TGT_FROM_HIT;
							state_d = S_DEL_REL;
						end else begin
							ctl.op = OP_SET_STATUS;
							ctl.st = ST_NOT_FOUND;
							state_d = S_DONE;
						end
					end
					RET_UNIP: begin
						ctl.op = found_q ? OP_UNINDEX : OP_RCLR;
						state_d = S_DS_CL;
					end
					RET_UNCL: begin
						ctl.op = found_q ? OP_UNINDEX : OP_RCLR;
						state_d = S_DS_END;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_DEL_REL: begin
				ctl.op = OP_RELEASE;
				state_d = S_DONE;
			end
			S_DS_START: begin
				ctl.op = OP_RCLR;
				state_d = S_DS_IP;
			end
			S_DS_IP: begin
				if (stat.tgt_ip_nz) begin
					ctl.op = OP_FIND_INIT;
					ctl.fsel = FSEL_TGT_IP;
					ret_d = RET_UNIP;
					state_d = S_FIND_RD;
				end else begin
					state_d = S_DS_CL;
				end
			end
			S_DS_CL: begin
				if (stat.tgt_cl_nz) begin
					ctl.op = OP_FIND_INIT;
					ctl.fsel = FSEL_TGT_CL;
					ret_d = RET_UNCL;
					state_d = S_FIND_RD;
				end else begin
					state_d = S_DS_END;
				end
			end
			S_DS_END: begin
				if (stat.r) begin
					ctl.op = OP_RELEASE;
				end
				state_d = ds_sweep_q ? S_SW_NEXT : S_DONE;
			end
			S_SWEEP_CHK: begin
				if (stat.live_high) begin
					ctl.op = OP_SW_INIT;
					state_d = S_SW_RD;
				end else begin
					state_d = S_ALLOC;
				end
			end
			S_SW_RD: begin
				if (stat.sweep_end) begin
					ctl.op = OP_SW_FIN;
					state_d = S_ALLOC;
				end else begin
					ctl.op = OP_SW_RD;
					state_d = S_SW_CMP;
				end
			end
			S_SW_CMP: begin
				if (stat.sweep_hit) begin
					ctl.op = OP_SW_CAPT;
					ds_sweep_d = 1'b1;
					state_d = S_DS_START;
				end else begin
					state_d = S_SW_NEXT;
				end
			end
			S_SW_NEXT: begin
				ctl.op = OP_SW_NEXT;
				state_d = S_SW_RD;
			end
			S_ALLOC: begin
				if (stat.free_nz) begin
					ctl.op = OP_POP_RD;
					state_d = S_POP;
				end else if (stat.table_full) begin
					ctl.op = OP_SET_STATUS;
					ctl.st = ST_FULL;
					state_d = S_DONE;
				end else begin
					ctl.op = OP_NEW_SLOT;
					state_d = S_WRITE;
				end
			end
			S_POP: begin
				ctl.op = OP_POP_TAKE;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				ctl.op = OP_WRITE_NEW;
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

### rtl/expiring_block_rule_table_unit.sv
// expiring block rule table: top level joining sequencer and datapath
// a key scan reads and compares each filled slot in turn (S_FIND_RD, S_FIND_CMP) until a match;
//   a slot delete adds one or two scans, an add may sweep 16 slots
// one command at a time: start is taken when busy is low, in the cycle after done
// done pulses for one cycle with the result beat; the receiver cannot stall it
// async reset clears counters and sequencer; slots past the fill mark are never read
module expiring_block_rule_table_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ebrt_pkg::in_beat_t  item,
	output logic                done,
	output ebrt_pkg::out_beat_t result
);
	import ebrt_pkg::*;

	// command bus from sequencer to datapath, status back
	ctl_t     ctl;
	dp_stat_t stat;

	// sequencer: owns state, return point of the key scan, and slot delete caller
	ebrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// datapath: slot memory, free stack, fill mark, sweep position, live count
	ebrt_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctl    (ctl),
		.stat   (stat),
		.result (result)
	);
endmodule
